>>> sv/ghp_pkg.sv
`default_nettype none
package ghp_pkg;

	localparam int HUE_W      = 16;
	localparam int FIX_W      = 17;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [HUE_W-1:0] GOLDEN_STEP = 16'd40503;
	localparam logic [FIX_W-1:0] ONE_FIX     = 17'd65536;
	localparam logic [FIX_W-1:0] ALPHA_FIX   = 17'd58982;
	localparam logic [CNT_W-1:0] MAX_COPIES  = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_SEED_HUE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COPIES     = 2'd3;

	typedef enum logic [2:0] {
		SEC_VTP = 3'd0,
		SEC_QVP = 3'd1,
		SEC_PVT = 3'd2,
		SEC_PQV = 3'd3,
		SEC_TPV = 3'd4,
		SEC_VPQ = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] seed_hue;
		logic [FIX_W-1:0] saturation;
		logic [FIX_W-1:0] brightness;
		logic [CNT_W-1:0] copies;
	} cfg_t;

	typedef struct packed {
		logic [FIX_W-1:0] red;
		logic [FIX_W-1:0] green;
		logic [FIX_W-1:0] blue;
		logic [CNT_W-1:0] ncopy;
	} qent_t;

	function automatic logic [FIX_W-1:0] lim_one(input logic [FIX_W-1:0] x);
		lim_one = (x > ONE_FIX) ? ONE_FIX : x;
	endfunction

	function automatic logic [CNT_W-1:0] lim_copies(input logic [CNT_W-1:0] n);
		lim_copies = (n > MAX_COPIES) ? MAX_COPIES : n;
	endfunction

endpackage
`default_nettype wire

>>> sv/golden_hue_hsv_palette_top.sv
// Path: the first copy of a color shows on the result side after its input transaction
// passes the hue step, two multiply stages, color select and queue write, copy register.
// Throughput: one input transaction per cycle while not full, into an 8-entry color queue;
// the copy emitter drains one color per min(copies, 64) pops, which sets the sustained rate.
// Reset (arst_n low, asynchronous): hue accumulator to zero, registers to their defaults
// (seed 0, saturation 1.0, brightness 1.0, copies 1), queue and pipeline empty.
`default_nettype none
module golden_hue_hsv_palette_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ghp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ghp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             restart,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [ghp_pkg::FIX_W-1:0]             red,
	output logic [ghp_pkg::FIX_W-1:0]             green,
	output logic [ghp_pkg::FIX_W-1:0]             blue,
	output logic [ghp_pkg::FIX_W-1:0]             alpha,
	output logic                                  last_copy
);

	// Configuration registers; the user must keep them written only while the block is idle;
	// this is not enforced here, so the pipeline reads them live instead of carrying a copy with each transaction.
	ghp_pkg::cfg_t  cfg_q;

	// Queue traffic between the color front end and the copy emitter.
	logic           q_wr_en;
	ghp_pkg::qent_t q_wr_data;
	logic           q_rd_en;
	ghp_pkg::qent_t q_rd_data;
	logic           q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed_hue   <= '0;
			cfg_q.saturation <= ghp_pkg::ONE_FIX;
			cfg_q.brightness <= ghp_pkg::ONE_FIX;
			cfg_q.copies     <= ghp_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ghp_pkg::REG_SEED_HUE:   cfg_q.seed_hue   <= cfg_data[ghp_pkg::HUE_W-1:0];
				ghp_pkg::REG_SATURATION: cfg_q.saturation <= cfg_data[ghp_pkg::FIX_W-1:0];
				ghp_pkg::REG_BRIGHTNESS: cfg_q.brightness <= cfg_data[ghp_pkg::FIX_W-1:0];
				ghp_pkg::REG_COPIES:     cfg_q.copies     <= cfg_data[ghp_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: step the hue, convert HSV to RGB, push finished colors and drop those with zero copies.
	// Its full flag counts queue slots held by queued colors and transactions still in flight.
	ghp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.restart    (restart),
		.full       (full),
		.wr_en      (q_wr_en),
		.wr_data    (q_wr_data),
		.release_en (q_rd_en)
	);

	// Color queue decoupling the two sides.
	ghp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr_en),
		.wr_data  (q_wr_data),
		.rd_en    (q_rd_en),
		.rd_data  (q_rd_data),
		.nonempty (q_nonempty)
	);

	// Back end: hold one color and emit it once per copy, marking the last.
	ghp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_data   (q_rd_data),
		.nonempty  (q_nonempty),
		.rd_en     (q_rd_en),
		.pop       (pop),
		.empty     (empty),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.last_copy (last_copy)
	);

endmodule
`default_nettype wire

>>> sv/ghp_front.sv
`default_nettype none
module ghp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ghp_pkg::cfg_t cfg,
	input  wire logic          push,
	input  wire logic          restart,
	output logic               full,
	output logic               wr_en,
	output ghp_pkg::qent_t     wr_data,
	input  wire logic          release_en
);

	localparam int PW = 2 * ghp_pkg::FIX_W;

	logic                         accept;
	logic [ghp_pkg::HUE_W-1:0]    hue_q;
	logic [ghp_pkg::HUE_W-1:0]    hue_next;
	logic [ghp_pkg::QCNT_W-1:0]   used_q;
	logic                         drop;

	logic                         valid_s1;
	logic [ghp_pkg::HUE_W+2:0]    h6_s1;

	logic                         valid_s2;
	ghp_pkg::sector_t             sector_s2;
	logic [ghp_pkg::FIX_W-1:0]    fs_s2;
	logic [ghp_pkg::FIX_W-1:0]    gs_s2;
	logic [ghp_pkg::FIX_W-1:0]    oms_s2;

	logic                         valid_s3;
	ghp_pkg::sector_t             sector_s3;
	logic [ghp_pkg::FIX_W-1:0]    p_s3;
	logic [ghp_pkg::FIX_W-1:0]    q_s3;
	logic [ghp_pkg::FIX_W-1:0]    t_s3;

	logic [ghp_pkg::FIX_W-1:0]    sat;
	logic [ghp_pkg::FIX_W-1:0]    val;
	logic [ghp_pkg::CNT_W-1:0]    ncopy;
	logic [ghp_pkg::HUE_W-1:0]    frac;
	logic [PW-1:0]                fs_prod;
	logic [PW-1:0]                gs_prod;
	logic [PW-1:0]                p_prod;
	logic [PW-1:0]                q_prod;
	logic [PW-1:0]                t_prod;

	assign full     = (used_q == ghp_pkg::QCNT_W'(ghp_pkg::QDEPTH));
	assign accept   = push && !full;
	assign hue_next = (restart ? cfg.seed_hue : hue_q) + ghp_pkg::GOLDEN_STEP;

	assign sat   = ghp_pkg::lim_one(cfg.saturation);
	assign val   = ghp_pkg::lim_one(cfg.brightness);
	assign ncopy = ghp_pkg::lim_copies(cfg.copies);
	assign frac  = h6_s1[ghp_pkg::HUE_W-1:0];

	assign fs_prod = PW'(frac) * PW'(sat);
	assign gs_prod = PW'(ghp_pkg::ONE_FIX - ghp_pkg::FIX_W'(frac)) * PW'(sat);
	assign p_prod  = PW'(val) * PW'(oms_s2);
	assign q_prod  = PW'(val) * PW'(ghp_pkg::ONE_FIX - fs_s2);
	assign t_prod  = PW'(val) * PW'(ghp_pkg::ONE_FIX - gs_s2);

	assign drop  = valid_s3 && (ncopy == '0);
	assign wr_en = valid_s3 && (ncopy != '0);

	always_comb begin
		wr_data.ncopy = ncopy;
		case (sector_s3)
			ghp_pkg::SEC_VTP: begin
				wr_data.red = val;  wr_data.green = t_s3; wr_data.blue = p_s3;
			end
			ghp_pkg::SEC_QVP: begin
				wr_data.red = q_s3; wr_data.green = val;  wr_data.blue = p_s3;
			end
			ghp_pkg::SEC_PVT: begin
				wr_data.red = p_s3; wr_data.green = val;  wr_data.blue = t_s3;
			end
			ghp_pkg::SEC_PQV: begin
				wr_data.red = p_s3; wr_data.green = q_s3; wr_data.blue = val;
			end
			ghp_pkg::SEC_TPV: begin
				wr_data.red = t_s3; wr_data.green = p_s3; wr_data.blue = val;
			end
			default: begin
				wr_data.red = val;  wr_data.green = p_s3; wr_data.blue = q_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q    <= '0;
			used_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				hue_q <= hue_next;
			end
			used_q <= used_q + ghp_pkg::QCNT_W'(accept) - ghp_pkg::QCNT_W'(release_en)
				- ghp_pkg::QCNT_W'(drop);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		h6_s1     <= (ghp_pkg::HUE_W+3)'(hue_next) * (ghp_pkg::HUE_W+3)'(6);
		sector_s2 <= ghp_pkg::sector_t'(h6_s1[ghp_pkg::HUE_W+2:ghp_pkg::HUE_W]);
		fs_s2     <= fs_prod[ghp_pkg::FIX_W+ghp_pkg::HUE_W-1:ghp_pkg::HUE_W];
		gs_s2     <= gs_prod[ghp_pkg::FIX_W+ghp_pkg::HUE_W-1:ghp_pkg::HUE_W];
		oms_s2    <= ghp_pkg::ONE_FIX - sat;
		sector_s3 <= sector_s2;
		p_s3      <= p_prod[ghp_pkg::FIX_W+ghp_pkg::HUE_W-1:ghp_pkg::HUE_W];
		q_s3      <= q_prod[ghp_pkg::FIX_W+ghp_pkg::HUE_W-1:ghp_pkg::HUE_W];
		t_s3      <= t_prod[ghp_pkg::FIX_W+ghp_pkg::HUE_W-1:ghp_pkg::HUE_W];
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ghp_pkg::QCNT_W'(ghp_pkg::QDEPTH))
		else $error("credit count above queue depth");

	a_no_write_and_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (wr_en != drop))
		else $error("finished item neither queued nor dropped exactly once");

endmodule
`default_nettype wire

>>> sv/ghp_fifo.sv
`default_nettype none
module ghp_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire ghp_pkg::qent_t wr_data,
	input  wire logic           rd_en,
	output ghp_pkg::qent_t      rd_data,
	output logic                nonempty
);

	ghp_pkg::qent_t              mem_q [ghp_pkg::QDEPTH];
	logic [ghp_pkg::QPTR_W-1:0]  wp_q;
	logic [ghp_pkg::QPTR_W-1:0]  rp_q;
	logic [ghp_pkg::QCNT_W-1:0]  cnt_q;

	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + ghp_pkg::QCNT_W'(wr_en) - ghp_pkg::QCNT_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cnt_q != ghp_pkg::QCNT_W'(ghp_pkg::QDEPTH)) || rd_en)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> nonempty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

>>> sv/ghp_back.sv
`default_nettype none
module ghp_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ghp_pkg::qent_t               rd_data,
	input  wire logic                         nonempty,
	output logic                              rd_en,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [ghp_pkg::FIX_W-1:0]         red,
	output logic [ghp_pkg::FIX_W-1:0]         green,
	output logic [ghp_pkg::FIX_W-1:0]         blue,
	output logic [ghp_pkg::FIX_W-1:0]         alpha,
	output logic                              last_copy
);

	ghp_pkg::qent_t              cur_q;
	logic                        valid_q;
	logic [ghp_pkg::CNT_W-1:0]   k_q;
	logic                        take;

	assign empty     = !valid_q;
	assign red       = cur_q.red;
	assign green     = cur_q.green;
	assign blue      = cur_q.blue;
	assign alpha     = ghp_pkg::ALPHA_FIX;
	assign last_copy = (k_q == cur_q.ncopy - 1'b1);
	assign take      = pop && valid_q;
	// load the next color when idle or when its last copy leaves
	assign rd_en     = nonempty && (!valid_q || (take && last_copy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (rd_en) begin
				valid_q <= 1'b1;
				k_q     <= '0;
			end else if (take) begin
				if (last_copy) begin
					valid_q <= 1'b0;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= rd_data;
		end
	end

	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cur_q.ncopy != '0) && (k_q < cur_q.ncopy))
		else $error("copy index outside the color's copy count");

endmodule
`default_nettype wire
